// File: rtl/ppmfg_pkg.sv
// ppmfg_pkg: shared types, codes and constants for the PPM frame generator.
// No dependencies; imported by every module in rtl/.
package ppmfg_pkg;

	// default number of channel slots in the value store
	localparam int MAX_CHANNELS_DEF = 8;

	// field and register widths
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 4;
	localparam int WVAL_W     = 12;
	localparam int CHV_W      = 11;
	localparam int CNT_W      = 4;
	localparam int PLT_W      = 10;
	localparam int FT_W       = 16;
	localparam int TICKS_W    = 16;
	localparam int ELAPSED_W  = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME    = 2'd2;

	// register reset values
	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 4'd8;
	localparam logic [PLT_W-1:0] PULSE_LOW_RST     = 10'd400;
	localparam logic [FT_W-1:0]  FRAME_TIME_RST    = 16'd22500;

	// timing and value limits, microseconds
	localparam logic [TICKS_W-1:0] GAP_MIN   = 16'd500;
	localparam logic [WVAL_W-1:0]  VAL_MIN   = 12'd1000;
	localparam logic [WVAL_W-1:0]  VAL_MAX   = 12'd2000;
	localparam logic [CHV_W-1:0]   VAL_RESET = 11'd1500;

	// timer status toward the result stage
	typedef struct packed {
		logic line_low;
		logic frame_start;
	} ppmfg_tstat_t;

endpackage

// File: rtl/ppmfg_chan_store.sv
// ppmfg_chan_store: channel value store, one write port and one read port.
// Depends on ppmfg_pkg. Entries reset to the default channel value.
module ppmfg_chan_store
	import ppmfg_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int CW           = $clog2(MAX_CHANNELS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [CW-1:0]    waddr,
	input  logic [CHV_W-1:0] wdata,
	input  logic [CW-1:0]    raddr,
	output logic [CHV_W-1:0] rdata
);

	logic [CHV_W-1:0] val_q [MAX_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				val_q[i] <= VAL_RESET;
			end
		end else if (we) begin
			val_q[waddr] <= wdata;
		end
	end

	// caller only uses rdata when raddr is in range
	assign rdata = val_q[raddr];

endmodule

// File: rtl/ppmfg_timer.sv
// ppmfg_timer: PPM segment countdown and frame sequencer, one step per tick.
// Depends on ppmfg_pkg; channel values come from ppmfg_chan_store.
module ppmfg_timer
	import ppmfg_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int CW           = $clog2(MAX_CHANNELS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  logic [CNT_W-1:0] channel_count,
	input  logic [PLT_W-1:0] pulse_low_time,
	input  logic [FT_W-1:0]  frame_time,
	input  logic [CHV_W-1:0] chan_value,
	output logic [CW-1:0]    chan_sel,
	output ppmfg_tstat_t     status
);

	localparam int EW = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;

	logic                 line_low_q, line_low_nxt;
	logic [CW-1:0]        cur_q, cur_nxt;
	logic [TICKS_W-1:0]   ticks_q, ticks_nxt;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_nxt;
	logic                 gap;
	logic [TICKS_W-1:0]   seg;
	logic [EW-1:0]        cnt_ext, eff_cnt;
	logic [ELAPSED_W-1:0] used;

	// channel count clamped to 1..MAX_CHANNELS
	always_comb begin
		cnt_ext = EW'(channel_count);
		if (cnt_ext == '0) begin
			eff_cnt = EW'(1);
		end else if (cnt_ext > EW'(MAX_CHANNELS)) begin
			eff_cnt = EW'(MAX_CHANNELS);
		end else begin
			eff_cnt = cnt_ext;
		end
	end

	assign used = (elapsed_q > ELAPSED_W'(frame_time)) ? '0 : elapsed_q;

	always_comb begin
		line_low_nxt = line_low_q;
		cur_nxt      = cur_q;
		ticks_nxt    = ticks_q;
		elapsed_nxt  = elapsed_q;
		gap          = 1'b0;
		seg          = TICKS_W'(1);
		if (tick) begin
			if (ticks_q == '0) begin
				if (!line_low_q) begin
					// start of a separator pulse
					line_low_nxt = 1'b1;
					seg          = (pulse_low_time == '0) ? TICKS_W'(1)
					               : TICKS_W'(pulse_low_time);
					elapsed_nxt  = elapsed_q + ELAPSED_W'(seg);
				end else if (EW'(cur_q) + EW'(1) >= eff_cnt) begin
					// last pulse done: sync gap
					line_low_nxt = 1'b0;
					cur_nxt      = '0;
					seg          = frame_time - FT_W'(used);
					if (seg < GAP_MIN) begin
						seg = GAP_MIN;
					end
					elapsed_nxt  = '0;
					gap          = 1'b1;
				end else begin
					// channel interval, measured start to start
					line_low_nxt = 1'b0;
					seg          = (chan_value > CHV_W'(pulse_low_time))
					               ? TICKS_W'(chan_value - CHV_W'(pulse_low_time))
					               : TICKS_W'(1);
					elapsed_nxt  = elapsed_q + ELAPSED_W'(seg);
					cur_nxt      = cur_q + CW'(1);
				end
				ticks_nxt = seg - TICKS_W'(1);
			end else begin
				ticks_nxt = ticks_q - TICKS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_low_q <= 1'b0;
			cur_q      <= '0;
			ticks_q    <= '0;
			elapsed_q  <= '0;
		end else begin
			line_low_q <= line_low_nxt;
			cur_q      <= cur_nxt;
			ticks_q    <= ticks_nxt;
			elapsed_q  <= elapsed_nxt;
		end
	end

	assign chan_sel           = cur_q;
	assign status.line_low    = line_low_nxt;
	assign status.frame_start = gap;

endmodule

// File: rtl/ppm_frame_generator_core.sv
// ppm_frame_generator_core: RC PPM frame generator top level.
// Depends on ppmfg_pkg, ppmfg_chan_store and ppmfg_timer.
// Pipeline: a beat accepted into the input register moves on into the result register
//   through one combinational pass, once the result register frees up.
// Throughput: one beat per cycle while result_stall does not back up the result register.
// Reset (arst_n low, async): both stages empty, registers at defaults,
//   channel values 1500, line high, first tick starts a separator pulse.
module ppm_frame_generator_core
	import ppmfg_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [IDX_W-1:0]      channel_index,
	input  logic [WVAL_W-1:0]     write_value,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  pin_level,
	output logic [CHV_W-1:0]      read_value,
	output logic                  accepted,
	output logic                  frame_start
);

	localparam int CW = $clog2(MAX_CHANNELS);

	// configuration registers
	logic [CNT_W-1:0] chan_cnt_q;
	logic [PLT_W-1:0] pulse_low_q;
	logic [FT_W-1:0]  frame_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q   <= CHANNEL_COUNT_RST;
			pulse_low_q  <= PULSE_LOW_RST;
			frame_time_q <= FRAME_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: chan_cnt_q   <= cfg_data[CNT_W-1:0];
				REG_PULSE_LOW:     pulse_low_q  <= cfg_data[PLT_W-1:0];
				REG_FRAME_TIME:    frame_time_q <= cfg_data[FT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: input register
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WVAL_W-1:0] wval_s1;
	logic              advance;
	logic              fire_s1;

	// result register frees up when empty or being taken this cycle
	assign advance    = !result_valid || !result_stall;
	assign fire_s1    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			cmd_s1  <= cmd_t'(cmd);
			idx_s1  <= channel_index;
			wval_s1 <= write_value;
		end
	end

	// decode of the held beat
	logic idx_ok, val_ok, wr_en, is_tick;

	assign idx_ok  = {1'b0, idx_s1} < (IDX_W+1)'(MAX_CHANNELS);
	assign val_ok  = (wval_s1 >= VAL_MIN) && (wval_s1 <= VAL_MAX);
	assign is_tick = fire_s1 && (cmd_s1 == CMD_TICK);
	assign wr_en   = fire_s1 && (cmd_s1 == CMD_WRITE) && idx_ok && val_ok;

	// channel store: the timer addresses it on ticks, reads use the beat's index
	logic [CW-1:0]    chan_sel, raddr;
	logic [CHV_W-1:0] rdata;
	ppmfg_tstat_t     tstat;

	assign raddr = (cmd_s1 == CMD_TICK) ? chan_sel : idx_s1[CW-1:0];

	ppmfg_chan_store #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.CW           (CW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_en),
		.waddr  (idx_s1[CW-1:0]),
		.wdata  (wval_s1[CHV_W-1:0]),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	ppmfg_timer #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.CW           (CW)
	) u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (is_tick),
		.channel_count  (chan_cnt_q),
		.pulse_low_time (pulse_low_q),
		.frame_time     (frame_time_q),
		.chan_value     (rdata),
		.chan_sel       (chan_sel),
		.status         (tstat)
	);

	// result fields of the held beat
	logic [CHV_W-1:0] rd_val;
	logic             acc;

	always_comb begin
		rd_val = '0;
		acc    = 1'b0;
		case (cmd_s1)
			CMD_TICK:  acc = 1'b1;
			CMD_WRITE: acc = idx_ok && val_ok;
			CMD_READ: begin
				acc    = idx_ok;
				rd_val = idx_ok ? rdata : '0;
			end
			default: ;
		endcase
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pin_level   <= !tstat.line_low;
			read_value  <= rd_val;
			accepted    <= acc;
			frame_start <= tstat.frame_start;
		end
	end

	// the sync gap always starts with the line high
	a_gap_high: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_start |-> pin_level)
		else $error("frame start with line low");

	// only ticks can start a frame, and ticks are always accepted
	a_gap_acc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_start |-> accepted && (read_value == '0))
		else $error("frame start on a non-tick beat");

	// stored values are always within the legal channel range
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (read_value != '0) |->
			accepted && (read_value >= CHV_W'(VAL_MIN)) && (read_value <= CHV_W'(VAL_MAX)))
		else $error("read value out of range");

	// a stalled beat in stage 1 is never lost while results back up
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1)
		else $error("stage 1 beat dropped under stall");

endmodule
